// ----- rtl/vlbp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vlbp_pkg;

  localparam int unsigned AddrW = 32;

  localparam logic [4:0] CL_UNKNOWN = 5'd0;
  localparam logic [4:0] CL_JMP     = 5'd1;
  localparam logic [4:0] CL_CJMP    = 5'd2;
  localparam logic [4:0] CL_CALL    = 5'd3;
  localparam logic [4:0] CL_RCALL   = 5'd4;
  localparam logic [4:0] CL_RJMP    = 5'd5;
  localparam logic [4:0] CL_RET     = 5'd6;
  localparam logic [4:0] CL_PUSH    = 5'd7;
  localparam logic [4:0] CL_POP     = 5'd8;
  localparam logic [4:0] CL_RETPOP  = 5'd9;
  localparam logic [4:0] CL_ADD     = 5'd10;
  localparam logic [4:0] CL_SWI     = 5'd11;
  localparam logic [4:0] CL_NOP     = 5'd12;
  localparam logic [4:0] CL_TRAP    = 5'd13;
  localparam logic [4:0] CL_MOV     = 5'd14;
  localparam logic [4:0] CL_STORE   = 5'd15;
  localparam logic [4:0] CL_LOAD    = 5'd16;

  // decoded instruction handed from decoder to target unit
  typedef struct packed {
    logic [2:0]       len;
    logic [4:0]       cls;
    logic             has_jump;
    logic             has_fall;
    logic             absolute;
    logic [AddrW-1:0] imm;
  } dec_t;

  // one result beat
  typedef struct packed {
    logic             fall_valid;
    logic [AddrW-1:0] fall_through;
    logic             jump_valid;
    logic [AddrW-1:0] jump_target;
    logic [4:0]       op_class;
    logic [2:0]       instr_length;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/vlbp_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vlbp_decode (
  input  wire logic [47:0]   instr_window,
  output vlbp_pkg::dec_t     dec
);

  // reverse the low s bits of n, then sign-extend from bit s-1 (s = 32: no extension)
  function automatic logic [31:0] rev_sext(input logic [31:0] n, input int unsigned s);
    logic [31:0] r;
    logic [31:0] v;
    for (int i = 0; i < 32; i++) begin
      r[i] = n[31-i];
    end
    v = r >> (32 - s);
    if (s < 32 && v[s-1]) begin
      v = v | ~((32'h1 << s) - 32'h1);
    end
    return v;
  endfunction

  logic [7:0]  b0, b1, b2, b3, b4, b5;
  logic [4:0]  ra, rb;
  logic [3:0]  sub6;
  logic [31:0] w32;
  logic [23:0] w24;
  logic [31:0] v32;
  logic        ld;

  assign b0 = instr_window[47:40];
  assign b1 = instr_window[39:32];
  assign b2 = instr_window[31:24];
  assign b3 = instr_window[23:16];
  assign b4 = instr_window[15:8];
  assign b5 = instr_window[7:0];

  assign ra   = {b0[1:0], b1[7:5]};
  assign rb   = b1[4:0];
  assign sub6 = {b0[1:0], b1[7:6]};
  assign w32  = {b2, b3, b4, b5};
  assign w24  = {b1, b2, b3};
  assign v32  = rev_sext(w32, 32);

  always_comb begin
    unique case (b0[3:2])
      2'd0: ld = 1'b0;
      2'd1: ld = 1'b1;
      2'd2: ld = b2[7];
      default: begin
        if (b2[7:6] == 2'd0) ld = 1'b0;
        else if (b2[7:6] != 2'd3) ld = 1'b1;
        else ld = b2[5];
      end
    endcase
  end

  always_comb begin
    dec          = '0;
    dec.cls      = vlbp_pkg::CL_UNKNOWN;
    unique case (b0[7:4])
      4'h0: begin
        dec.len = 3'd2;
        unique case (b0[3:2])
          2'd3: begin
            dec.cls      = vlbp_pkg::CL_JMP;
            dec.imm      = rev_sext({22'd0, b0[1:0], b1}, 10);
            dec.has_jump = 1'b1;
          end
          2'd2: dec.cls = vlbp_pkg::CL_ADD;
          2'd1: dec.cls = (ra == 5'd0 && rb == 5'd3) ? vlbp_pkg::CL_SWI : vlbp_pkg::CL_NOP;
          default: begin
            if (rb[4]) dec.cls = (ra == 5'd0) ? vlbp_pkg::CL_NOP : vlbp_pkg::CL_ADD;
            else dec.cls = (ra == 5'd0) ? vlbp_pkg::CL_TRAP : vlbp_pkg::CL_MOV;
          end
        endcase
      end
      4'h2: begin
        dec.len = 3'd3;
        dec.cls = ld ? vlbp_pkg::CL_LOAD : vlbp_pkg::CL_STORE;
      end
      4'h4: begin
        dec.len = 3'd3;
        priority if (b0[3:0] <= 4'd5) begin
          dec.cls      = vlbp_pkg::CL_CJMP;
          dec.imm      = rev_sext({24'd0, b2}, 8);
          dec.has_jump = 1'b1;
          dec.has_fall = 1'b1;
        end else if (b0[3:0] == 4'd6) begin
          dec.cls      = vlbp_pkg::CL_JMP;
          dec.imm      = rev_sext({16'd0, b1, b2}, 16);
          dec.has_jump = 1'b1;
        end else if (b0[3:0] == 4'd7) begin
          priority if (b1[7:4] >= 4'd2 && b1[7:4] <= 4'd7) begin
            dec.cls      = vlbp_pkg::CL_CJMP;
            dec.imm      = rev_sext({20'd0, b1[3:0], b2}, 12);
            dec.has_jump = 1'b1;
            dec.has_fall = 1'b1;
          end else if (b1[7:4] == 4'd10) begin
            dec.cls = vlbp_pkg::CL_PUSH;
          end else if (b1[7:4] == 4'd11) begin
            dec.cls = vlbp_pkg::CL_RETPOP;
          end else if (b1[7:4] == 4'd12) begin
            dec.cls = vlbp_pkg::CL_POP;
          end else if (b1[7:4] == 4'd13) begin
            unique case (b1[1:0])
              2'd0: dec.cls = vlbp_pkg::CL_RET;
              2'd1: dec.cls = vlbp_pkg::CL_RCALL;
              2'd2: dec.cls = (b2[7:3] == 5'd9) ? vlbp_pkg::CL_RET : vlbp_pkg::CL_RJMP;
              default: dec.cls = vlbp_pkg::CL_UNKNOWN;
            endcase
          end else begin
            dec.cls = vlbp_pkg::CL_UNKNOWN;
          end
        end else if (b0[3:2] == 2'd2) begin
          dec.cls      = vlbp_pkg::CL_CALL;
          dec.imm      = rev_sext({14'd0, b0[1:0], b1, b2}, 18);
          dec.has_jump = 1'b1;
        end else begin
          dec.cls = vlbp_pkg::CL_UNKNOWN;
        end
      end
      4'h3, 4'h5, 4'h6, 4'h7: dec.len = 3'd3;
      4'h8, 4'h9: dec.len = 3'd6;
      4'hA: begin
        dec.len = 3'd6;
        if (b0[3:2] == 2'd0) begin
          dec.cls      = vlbp_pkg::CL_CJMP;
          dec.imm      = rev_sext({4'd0, w32[27:0]}, 28);
          dec.has_jump = 1'b1;
          dec.has_fall = 1'b1;
        end else if (b0[3:2] == 2'd1) begin
          dec.imm = v32;
          priority if (sub6 == 4'd0) begin
            dec.cls      = vlbp_pkg::CL_CALL;
            dec.has_jump = 1'b1;
          end else if (sub6 == 4'd1) begin
            dec.cls      = vlbp_pkg::CL_JMP;
            dec.has_jump = 1'b1;
          end else if (sub6 == 4'd2 || sub6 == 4'd3) begin
            dec.cls      = vlbp_pkg::CL_CJMP;
            dec.has_jump = 1'b1;
            dec.has_fall = 1'b1;
          end else if (sub6 == 4'd4) begin
            dec.cls      = vlbp_pkg::CL_JMP;
            dec.has_jump = 1'b1;
            dec.absolute = 1'b1;
          end else if (sub6 == 4'd5) begin
            // jmal when bit 0 of the second byte is set, jma otherwise
            dec.cls      = b1[0] ? vlbp_pkg::CL_CALL : vlbp_pkg::CL_JMP;
            dec.has_jump = 1'b1;
          end else begin
            dec.imm = '0;
          end
        end
      end
      4'hC: dec.len = 3'd4;
      4'hD: begin
        dec.len = 3'd4;
        priority if (b0[3:0] <= 4'd3) begin
          dec.cls      = vlbp_pkg::CL_CJMP;
          dec.imm      = rev_sext({20'd0, b2[3:0], b3}, 12);
          dec.has_jump = 1'b1;
          dec.has_fall = 1'b1;
        end else if (b0[3:0] == 4'd4) begin
          dec.cls      = vlbp_pkg::CL_CALL;
          dec.imm      = rev_sext({8'd0, w24}, 24);
          dec.has_jump = 1'b1;
        end else if (b0[3:0] == 4'd5) begin
          dec.cls      = vlbp_pkg::CL_JMP;
          dec.imm      = rev_sext({8'd0, w24}, 24);
          dec.has_jump = 1'b1;
        end else if (b0[3:0] <= 4'd7) begin
          dec.cls      = vlbp_pkg::CL_CJMP;
          dec.imm      = rev_sext({8'd0, w24}, 24);
          dec.has_jump = 1'b1;
          dec.has_fall = 1'b1;
        end else if (b0[3:0] <= 4'd11) begin
          dec.cls = vlbp_pkg::CL_ADD;
        end else begin
          dec.cls = vlbp_pkg::CL_UNKNOWN;
        end
      end
      default: dec.len = 3'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/vlbp_target.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vlbp_target (
  input  wire logic [31:0]   pc_address,
  input  wire vlbp_pkg::dec_t dec,
  output vlbp_pkg::res_t     res
);

  logic [31:0] rel_sum;
  logic [31:0] fall_sum;

  // address arithmetic wraps at 32 bits
  assign rel_sum  = pc_address + dec.imm;
  assign fall_sum = pc_address + {29'd0, dec.len};

  always_comb begin
    res.instr_length = dec.len;
    res.op_class     = dec.cls;
    res.jump_valid   = dec.has_jump;
    res.fall_valid   = dec.has_fall;
    if (!dec.has_jump) res.jump_target = '0;
    else if (dec.absolute) res.jump_target = dec.imm;
    else res.jump_target = rel_sum;
    res.fall_through = dec.has_fall ? fall_sum : 32'd0;
  end

endmodule

`default_nettype wire

// ----- rtl/variable_length_branch_predecoder_core.sv -----
// pipeline: input register, then result register; a beat passes through both to the output
// throughput: one instruction per cycle unless the output stalls; the decode and the target adder sit between
// the two registers
// reset: synchronous active-low rst_n clears both stage valid flags; data regs keep value
`timescale 1ns / 1ps
`default_nettype none

module variable_length_branch_predecoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // instr_window[47:0], pc_address[79:48]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata   // instr_length[2:0], op_class[7:3],
                                       // jump_target[39:8], jump_valid[40],
                                       // fall_through[72:41], fall_valid[73], zero[79:74]
);

  logic           s1_valid_r;
  logic [47:0]    win_r;
  logic [31:0]    pc_r;
  logic           out_valid_r;
  vlbp_pkg::res_t res_r;

  vlbp_pkg::dec_t dec;
  vlbp_pkg::res_t res;
  logic           s2_ready;

  assign s2_ready  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s2_ready;

  vlbp_decode u_decode (
    .instr_window (win_r),
    .dec          (dec)
  );

  vlbp_target u_target (
    .pc_address (pc_r),
    .dec        (dec),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (s2_ready) out_valid_r <= s1_valid_r;
    end
    if (in_tready && in_tvalid) begin
      win_r <= in_tdata[47:0];
      pc_r  <= in_tdata[79:48];
    end
    if (s2_ready && s1_valid_r) res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r};

  // stalled output with a full input stage must block new beats
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while pipeline full");

  a_fall_is_cjmp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.fall_valid) |->
      (res_r.jump_valid && res_r.op_class == vlbp_pkg::CL_CJMP))
    else $error("fall-through without conditional branch");

  a_badlen_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.instr_length == 3'd0) |->
      (res_r.op_class == vlbp_pkg::CL_UNKNOWN && !res_r.jump_valid))
    else $error("unsupported length decoded");

  a_nojump_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_r.jump_valid) |-> (res_r.jump_target == 32'd0))
    else $error("target set without jump");

endmodule

`default_nettype wire

// ----- test/tb_variable_length_branch_predecoder_core.sv -----
`timescale 1ns / 1ps

module tb_variable_length_branch_predecoder_core;

  localparam int NUM_DIRECTED = 28;
  localparam int NUM_RANDOM   = 1450;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int HOLD_CYCLES  = 120;

  typedef struct packed {
    logic [47:0] win;
    logic [31:0] pc;
    logic        lit;   // expected length and class typed in, targets zero
    logic [2:0]  len;
    logic [4:0]  cls;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;   // instr_window[47:0], pc_address[79:48]
  logic        out_tvalid;
  logic        out_tready;
  logic [79:0] out_tdata;  // instr_length[2:0], op_class[7:3], jump_target[39:8],
                           // jump_valid[40], fall_through[72:41], fall_valid[73]

  vlbp_pkg::res_t offered_decode;    // expectation for the beat currently on the input
  vlbp_pkg::res_t predicted_decodes[$];
  int   mismatches = 0;
  int   beats_in = 0;
  int   cycle_count = 0;
  logic held_off = 1'b0;

  variable_length_branch_predecoder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // reverse the low w bits, then sign-extend from bit w-1
  function automatic logic [31:0] rev_sext(input logic [31:0] v, input int w);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < w; i++) r[i] = v[w-1-i];
    for (int i = w; i < 32; i++) r[i] = r[w-1];
    return r;
  endfunction

  function automatic vlbp_pkg::res_t predecode(input logic [47:0] win,
                                               input logic [31:0] pc);
    logic [7:0]     b0, b1, b2, b3, b4, b5;
    logic [4:0]     ra, rb;
    logic [3:0]     sub6;
    logic [31:0]    imm, w32;
    logic           jv, fv, absol, ld;
    vlbp_pkg::res_t r;
    {b0, b1, b2, b3, b4, b5} = win;
    r = '0;
    imm = '0;
    jv = 1'b0;
    fv = 1'b0;
    absol = 1'b0;
    w32 = {b2, b3, b4, b5};
    ra = {b0[1:0], b1[7:5]};
    rb = b1[4:0];
    sub6 = {b0[1:0], b1[7:6]};
    case (b0[7:4])
      4'h0: begin
        r.instr_length = 3'd2;
        case (b0[3:2])
          2'd3: begin
            r.op_class = vlbp_pkg::CL_JMP;
            imm = rev_sext({22'd0, b0[1:0], b1}, 10);
            jv = 1'b1;
          end
          2'd2: r.op_class = vlbp_pkg::CL_ADD;
          2'd1: r.op_class = (ra == 5'd0 && rb == 5'd3) ? vlbp_pkg::CL_SWI : vlbp_pkg::CL_NOP;
          default: begin
            if (rb[4]) r.op_class = (ra == 5'd0) ? vlbp_pkg::CL_NOP : vlbp_pkg::CL_ADD;
            else r.op_class = (ra == 5'd0) ? vlbp_pkg::CL_TRAP : vlbp_pkg::CL_MOV;
          end
        endcase
      end
      4'h2: begin
        r.instr_length = 3'd3;
        case (b0[3:2])
          2'd0: ld = 1'b0;
          2'd1: ld = 1'b1;
          2'd2: ld = b2[7];
          default: ld = (b2[7:6] == 2'd3) ? b2[5] : (b2[7:6] != 2'd0);
        endcase
        r.op_class = ld ? vlbp_pkg::CL_LOAD : vlbp_pkg::CL_STORE;
      end
      4'h4: begin
        r.instr_length = 3'd3;
        case (b0[3:0])
          4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: begin
            r.op_class = vlbp_pkg::CL_CJMP;
            imm = rev_sext({24'd0, b2}, 8);
            jv = 1'b1;
            fv = 1'b1;
          end
          4'd6: begin
            r.op_class = vlbp_pkg::CL_JMP;
            imm = rev_sext({16'd0, b1, b2}, 16);
            jv = 1'b1;
          end
          4'd7: begin
            case (b1[7:4])
              4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7: begin
                r.op_class = vlbp_pkg::CL_CJMP;
                imm = rev_sext({20'd0, b1[3:0], b2}, 12);
                jv = 1'b1;
                fv = 1'b1;
              end
              4'd10: r.op_class = vlbp_pkg::CL_PUSH;
              4'd11: r.op_class = vlbp_pkg::CL_RETPOP;
              4'd12: r.op_class = vlbp_pkg::CL_POP;
              4'd13: begin
                case (b1[1:0])
                  2'd0: r.op_class = vlbp_pkg::CL_RET;
                  2'd1: r.op_class = vlbp_pkg::CL_RCALL;
                  2'd2: r.op_class = (b2[7:3] == 5'd9) ? vlbp_pkg::CL_RET
                                                       : vlbp_pkg::CL_RJMP;
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
          4'd8, 4'd9, 4'd10, 4'd11: begin
            r.op_class = vlbp_pkg::CL_CALL;
            imm = rev_sext({14'd0, b0[1:0], b1, b2}, 18);
            jv = 1'b1;
          end
          default: ;
        endcase
      end
      4'hA: begin
        r.instr_length = 3'd6;
        if (b0[3:2] == 2'd0) begin
          r.op_class = vlbp_pkg::CL_CJMP;
          imm = rev_sext({4'd0, w32[27:0]}, 28);
          jv = 1'b1;
          fv = 1'b1;
        end else if (b0[3:2] == 2'd1) begin
          imm = rev_sext(w32, 32);
          jv = 1'b1;
          case (sub6)
            4'd0: r.op_class = vlbp_pkg::CL_CALL;
            4'd1: r.op_class = vlbp_pkg::CL_JMP;
            4'd2, 4'd3: begin
              r.op_class = vlbp_pkg::CL_CJMP;
              fv = 1'b1;
            end
            4'd4: begin
              r.op_class = vlbp_pkg::CL_JMP;
              absol = 1'b1;
            end
            // bit 0 of the second byte picks the linking form
            4'd5: r.op_class = b1[0] ? vlbp_pkg::CL_CALL : vlbp_pkg::CL_JMP;
            default: jv = 1'b0;
          endcase
        end
      end
      4'hD: begin
        r.instr_length = 3'd4;
        case (b0[3:0])
          4'd0, 4'd1, 4'd2, 4'd3: begin
            r.op_class = vlbp_pkg::CL_CJMP;
            imm = rev_sext({20'd0, b2[3:0], b3}, 12);
            jv = 1'b1;
            fv = 1'b1;
          end
          4'd4: begin
            r.op_class = vlbp_pkg::CL_CALL;
            imm = rev_sext({8'd0, b1, b2, b3}, 24);
            jv = 1'b1;
          end
          4'd5: begin
            r.op_class = vlbp_pkg::CL_JMP;
            imm = rev_sext({8'd0, b1, b2, b3}, 24);
            jv = 1'b1;
          end
          4'd6, 4'd7: begin
            r.op_class = vlbp_pkg::CL_CJMP;
            imm = rev_sext({8'd0, b1, b2, b3}, 24);
            jv = 1'b1;
            fv = 1'b1;
          end
          4'd8, 4'd9, 4'd10, 4'd11: r.op_class = vlbp_pkg::CL_ADD;
          default: ;
        endcase
      end
      4'h3, 4'h5, 4'h6, 4'h7: r.instr_length = 3'd3;
      4'h8, 4'h9: r.instr_length = 3'd6;
      4'hC: r.instr_length = 3'd4;
      default: ;
    endcase
    r.jump_valid = jv;
    r.fall_valid = fv;
    if (jv) r.jump_target = absol ? imm : pc + imm;
    if (fv) r.fall_through = pc + {29'd0, r.instr_length};
    return r;
  endfunction

  function automatic stim_row_t stim_row(input int k);
    stim_row_t s;
    case (k)
      0:  s = {48'h0000_0000_0000, 32'h0000_0000, 1'b1, 3'd2, vlbp_pkg::CL_TRAP};
      1:  s = {48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 3'd0, vlbp_pkg::CL_UNKNOWN};
      2:  s = {48'hB123_4567_89AB, 32'h0000_1000, 1'b1, 3'd0, vlbp_pkg::CL_UNKNOWN};
      3:  s = {48'h3A5A_5A5A_5A5A, 32'h0000_2000, 1'b1, 3'd3, vlbp_pkg::CL_UNKNOWN};
      4:  s = {48'h90FF_0000_FFFF, 32'h0000_3000, 1'b1, 3'd6, vlbp_pkg::CL_UNKNOWN};
      5:  s = {48'hC7C7_C7C7_C7C7, 32'h0000_4000, 1'b1, 3'd4, vlbp_pkg::CL_UNKNOWN};
      6:  s = {48'h0DFF_0000_0000, 32'hFFFF_FFF0, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      7:  s = {48'h0800_0000_0000, 32'h0000_0100, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      8:  s = {48'h0403_0000_0000, 32'h0000_0200, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      9:  s = {48'h0420_0000_0000, 32'h0000_0300, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      10: s = {48'h0025_0000_0000, 32'h0000_0400, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      11: s = {48'h2000_0000_0000, 32'h0000_0500, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      12: s = {48'h2C00_E000_0000, 32'h0000_0600, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      13: s = {48'h4000_8000_0000, 32'hFFFF_FFFE, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      14: s = {48'h47A0_0000_0000, 32'h0000_0700, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      15: s = {48'h47B0_0000_0000, 32'h0000_0800, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      16: s = {48'h47C0_0000_0000, 32'h0000_0900, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      17: s = {48'h47D2_4800_0000, 32'h0000_0A00, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      18: s = {48'h47D1_0000_0000, 32'h0000_0B00, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      19: s = {48'h47D2_0000_0000, 32'h0000_0C00, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      20: s = {48'h4BFF_FF00_0000, 32'h0000_0000, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      21: s = {48'hA0FF_FFFF_FFFF, 32'h8000_0000, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      22: s = {48'hA500_0000_0001, 32'h1234_5678, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      23: s = {48'hA541_1234_5678, 32'h0000_0D00, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      24: s = {48'hA540_8765_4321, 32'h0000_0E00, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      25: s = {48'hD400_0001_0000, 32'h0000_0F00, 1'b0, 3'd0, vlbp_pkg::CL_UNKNOWN};
      26: s = {48'hDC00_0000_0000, 32'h0000_1100, 1'b1, 3'd4, vlbp_pkg::CL_UNKNOWN};
      default: s = {48'hA8FF_FFFF_FFFF, 32'h0000_1200, 1'b1, 3'd6, vlbp_pkg::CL_UNKNOWN};
    endcase
    return s;
  endfunction

  // mostly back to back or short gaps, a few long ones, plus gap-free stretches
  function automatic int pick_gap(input int n);
    int roll;
    roll = $urandom_range(0, 99);
    if ((n % 200) >= 150) return 0;
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic offer(input logic [47:0] win, input logic [31:0] pc,
                       input vlbp_pkg::res_t want, input int gap);
    in_tdata <= {pc, win};
    offered_decode <= want;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    vlbp_pkg::res_t want;
    vlbp_pkg::res_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        predicted_decodes.push_back(offered_decode);
        beats_in++;
      end
      if (out_tvalid && out_tready) begin
        got = out_tdata[73:0];
        if (predicted_decodes.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = predicted_decodes.pop_front();
          check_field("instr_length", 32'(want.instr_length), 32'(got.instr_length));
          check_field("op_class", 32'(want.op_class), 32'(got.op_class));
          check_field("jump_target", want.jump_target, got.jump_target);
          check_field("jump_valid", 32'(want.jump_valid), 32'(got.jump_valid));
          check_field("fall_through", want.fall_through, got.fall_through);
          check_field("fall_valid", 32'(want.fall_valid), 32'(got.fall_valid));
          check_field("tdata pad", 32'd0, 32'(out_tdata[79:74]));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_variable_length_branch_predecoder_core: errors");
      $finish;
    end
  end

  initial begin : sink
    int roll;
    out_tready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!held_off && beats_in >= 300) begin
        // long hold-off so the pipeline fills and backs up the input
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
          out_tready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end else if (roll < 90) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end else if (roll < 95) begin
          out_tready <= 1'b0;
          repeat ($urandom_range(8, 40)) @(posedge clk);
        end else begin
          out_tready <= 1'b1;
          repeat ($urandom_range(50, 150)) @(posedge clk);
        end
      end
    end
  end

  initial begin : source
    stim_row_t      row;
    vlbp_pkg::res_t want;
    logic [47:0]    win;
    logic [31:0]    pc;
    int             roll;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    offered_decode <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int k = 0; k < NUM_DIRECTED; k++) begin
      row = stim_row(k);
      if (row.lit) begin
        want = '0;
        want.instr_length = row.len;
        want.op_class = row.cls;
      end else begin
        want = predecode(row.win, row.pc);
      end
      offer(row.win, row.pc, want, pick_gap(k));
    end

    for (int k = 0; k < NUM_RANDOM; k++) begin
      win = 48'({$urandom(), $urandom()});
      roll = $urandom_range(0, 99);
      // steer toward the decoded length codes and their sub-opcode fields
      if (roll < 15) begin
        win[47:44] = 4'h0;
      end else if (roll < 27) begin
        win[47:44] = 4'h2;
      end else if (roll < 52) begin
        win[47:44] = 4'h4;
        if ($urandom_range(0, 1) == 1) begin
          win[43:40] = 4'd7;
          if ($urandom_range(0, 1) == 1) win[39:36] = 4'($urandom_range(10, 13));
        end
      end else if (roll < 72) begin
        win[47:44] = 4'hA;
        if ($urandom_range(0, 2) != 0) win[43:42] = 2'd1;
      end else if (roll < 87) begin
        win[47:44] = 4'hD;
      end
      roll = $urandom_range(0, 99);
      if (roll < 10) pc = {28'hFFF_FFFF, 4'($urandom_range(0, 15))};
      else if (roll < 15) pc = $urandom_range(0, 15);
      else pc = $urandom();
      offer(win, pc, predecode(win, pc), pick_gap(NUM_DIRECTED + k));
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_variable_length_branch_predecoder_core: clean");
    end else begin
      $display("tb_variable_length_branch_predecoder_core: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/vlbp_pkg.sv
rtl/vlbp_decode.sv
rtl/vlbp_target.sv
rtl/variable_length_branch_predecoder_core.sv
test/tb_variable_length_branch_predecoder_core.sv
